// ----- rtl/trapezoidal_pulse_shaper_assert.svh -----
// assertion macros used by the checker file
`ifndef TRAPEZOIDAL_PULSE_SHAPER_ASSERT_SVH
`define TRAPEZOIDAL_PULSE_SHAPER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define TPS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tps check failed");

// next-cycle implication, disabled while in reset
`define TPS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tps check failed");

`endif

// ----- rtl/tps_pkg.sv -----
`default_nettype none
package tps_pkg;

   localparam int SAMPLE_BITS    = 14;
   localparam int DELTA_BITS     = SAMPLE_BITS + 2;
   localparam int SUM_BITS       = 24;
   localparam int RISE_BITS      = 9;
   localparam int FLAT_BITS      = 8;
   localparam int GAIN_BITS      = 17;
   localparam int LEN_BITS       = 13;
   localparam int DIST_BITS      = 14;
   localparam int COUNT_BITS     = 12;
   localparam int SHAPED_BITS    = 16;
   localparam int FRAC_BITS      = 16;
   localparam int PROD_BITS      = SUM_BITS + GAIN_BITS + 1;
   localparam int Q_BITS         = PROD_BITS - FRAC_BITS;
   localparam int OUT_DEPTH      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 17;

   localparam logic [COUNT_BITS-1:0] MAX_COUNT = {COUNT_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RISE_LEN  = 2'd0,
      CSR_FLAT_LEN  = 2'd1,
      CSR_NORM_GAIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [RISE_BITS-1:0] rise_len;
      logic [FLAT_BITS-1:0] flat_len;
      logic [GAIN_BITS-1:0] norm_gain;
   } tps_cfg_type;

   typedef struct packed {
      logic                  valid;
      logic                  first;
      logic                  last;
      logic [COUNT_BITS-1:0] idx;
   } tps_ctl_type;

   typedef struct packed {
      logic                          peak_valid;
      logic [COUNT_BITS-1:0]         peak_index;
      logic signed [SHAPED_BITS-1:0] peak_value;
      logic signed [SHAPED_BITS-1:0] shaped;
   } tps_rsp_type;

endpackage
`default_nettype wire

// ----- rtl/tps_ram.sv -----
`default_nettype none
module tps_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule
`default_nettype wire

// ----- rtl/tps_delay.sv -----
`default_nettype none
module tps_delay import tps_pkg::*; #(
   parameter int MAX_RISE = 256,
   parameter int MAX_FLAT = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
   input  wire logic                          in_first,
   input  wire logic                          in_last,
   input  wire tps_cfg_type                   cfg,
   output tps_ctl_type                        out_ctl,
   output logic signed [SAMPLE_BITS-1:0]      out_sample,
   output logic signed [SAMPLE_BITS-1:0]      out_tap_k,
   output logic signed [SAMPLE_BITS-1:0]      out_tap_kl,
   output logic signed [SAMPLE_BITS-1:0]      out_tap_2kl
);

   localparam int DEPTH = 2 * MAX_RISE + MAX_FLAT;
   localparam int AW    = $clog2(DEPTH);

   logic [AW-1:0]         wp_ff, wp_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] idx;
   logic [LEN_BITS-1:0]   rise_ext, flat_ext, k, l;
   logic [DIST_BITS-1:0]  d1, d2, d3, idx_ext;
   logic [2:0]            mask_in, mask_ff;
   logic [AW-1:0]         addr1, addr2, addr3;
   tps_ctl_type           ctl_ff, ctl_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] rd1, rd2, rd3;

   // address of the sample d positions back from the write pointer
   function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] wp,
                                              input logic [DIST_BITS-1:0] d);
      logic [AW:0] diff;
      diff = {1'b0, wp} - {1'b0, d[AW-1:0]};
      if (diff[AW]) begin
         diff = diff + (AW+1)'(DEPTH);
      end
      return diff[AW-1:0];
   endfunction

   always_comb begin
      rise_ext = LEN_BITS'(cfg.rise_len);
      flat_ext = LEN_BITS'(cfg.flat_len);
      if (rise_ext == '0) begin
         k = LEN_BITS'(1);
      end else if (rise_ext > LEN_BITS'(MAX_RISE)) begin
         k = LEN_BITS'(MAX_RISE);
      end else begin
         k = rise_ext;
      end
      if (flat_ext > LEN_BITS'(MAX_FLAT - 1)) begin
         l = LEN_BITS'(MAX_FLAT - 1);
      end else begin
         l = flat_ext;
      end
      d1 = DIST_BITS'(k);
      d2 = DIST_BITS'(k) + DIST_BITS'(l);
      d3 = d2 + DIST_BITS'(k);

      idx     = in_first ? '0 : count_ff;
      idx_ext = DIST_BITS'(idx);
      // taps older than the record start read as zero
      mask_in = {d3 <= idx_ext, d2 <= idx_ext, d1 <= idx_ext};

      addr1 = tap_addr(wp_ff, d1);
      addr2 = tap_addr(wp_ff, d2);
      addr3 = tap_addr(wp_ff, d3);

      wp_in    = wp_ff;
      count_in = count_ff;
      if (accept) begin
         wp_in    = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         count_in = (idx == MAX_COUNT) ? idx : idx + COUNT_BITS'(1);
      end

      ctl_in.valid = accept;
      ctl_in.first = in_first;
      ctl_in.last  = in_last;
      ctl_in.idx   = idx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         count_ff     <= '0;
         ctl_ff.valid <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.first <= ctl_in.first;
      ctl_ff.last  <= ctl_in.last;
      ctl_ff.idx   <= ctl_in.idx;
      mask_ff      <= mask_in;
      sample_ff    <= in_sample;
   end

   tps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_near (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wp_ff),
      .wr_data   (in_sample),
      .rd_addr_a (addr1),
      .rd_addr_b (addr2),
      .rd_data_a (rd1),
      .rd_data_b (rd2)
   );

   tps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_ram_far (
      .clock     (clock),
      .wr_en     (accept),
      .wr_addr   (wp_ff),
      .wr_data   (in_sample),
      .rd_addr_a (addr3),
      .rd_addr_b (addr3),
      .rd_data_a (rd3),
      .rd_data_b ()
   );

   assign out_ctl     = ctl_ff;
   assign out_sample  = sample_ff;
   assign out_tap_k   = mask_ff[0] ? $signed(rd1) : '0;
   assign out_tap_kl  = mask_ff[1] ? $signed(rd2) : '0;
   assign out_tap_2kl = mask_ff[2] ? $signed(rd3) : '0;

endmodule
`default_nettype wire

// ----- rtl/tps_arith.sv -----
`default_nettype none
module tps_arith import tps_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tps_ctl_type                   ctl,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic signed [SAMPLE_BITS-1:0] tap_k,
   input  wire logic signed [SAMPLE_BITS-1:0] tap_kl,
   input  wire logic signed [SAMPLE_BITS-1:0] tap_2kl,
   input  wire logic [GAIN_BITS-1:0]          norm_gain,
   output logic                               push,
   output tps_rsp_type                        push_data
);

   logic signed [DELTA_BITS-1:0]  delta;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic                          v2_ff, last2_ff, v3_ff, last3_ff;
   logic [COUNT_BITS-1:0]         idx2_ff, idx3_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [Q_BITS-1:0]      q;
   logic signed [SHAPED_BITS-1:0] shaped;
   logic signed [SHAPED_BITS-1:0] peak_ff, peak_in;
   logic [COUNT_BITS-1:0]         pos_ff, pos_in;

   always_comb begin
      delta = DELTA_BITS'(sample) - DELTA_BITS'(tap_k) - DELTA_BITS'(tap_kl)
            + DELTA_BITS'(tap_2kl);
      sum_in = sum_ff;
      if (ctl.valid) begin
         sum_in = (ctl.first ? '0 : sum_ff) + SUM_BITS'(delta);
      end
      prod_in = sum_ff * $signed({1'b0, norm_gain});
   end

   // floor shift, then clamp to the output range
   always_comb begin
      q = prod_ff[PROD_BITS-1:FRAC_BITS];
      if (q > $signed(Q_BITS'(32767))) begin
         shaped = 16'sh7fff;
      end else if (q < $signed(-Q_BITS'(32768))) begin
         shaped = 16'sh8000;
      end else begin
         shaped = q[SHAPED_BITS-1:0];
      end
      peak_in = peak_ff;
      pos_in  = pos_ff;
      if (v3_ff && (idx3_ff == '0 || shaped > peak_ff)) begin
         peak_in = shaped;
         pos_in  = idx3_ff;
      end
      push                 = v3_ff;
      push_data.shaped     = shaped;
      push_data.peak_valid = last3_ff;
      push_data.peak_value = last3_ff ? peak_in : '0;
      push_data.peak_index = last3_ff ? pos_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         peak_ff <= '0;
         pos_ff  <= '0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         peak_ff <= peak_in;
         pos_ff  <= pos_in;
         v2_ff   <= ctl.valid;
         v3_ff   <= v2_ff;
      end
      last2_ff <= ctl.last;
      idx2_ff  <= ctl.idx;
      last3_ff <= last2_ff;
      idx3_ff  <= idx2_ff;
      prod_ff  <= prod_in;
   end

endmodule
`default_nettype wire

// ----- rtl/tps_out_fifo.sv -----
`default_nettype none
module tps_out_fifo import tps_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire tps_rsp_type push_data,
   input  wire logic        pop,
   output logic             out_valid,
   output tps_rsp_type      out_data
);

   localparam int PTR_BITS = $clog2(OUT_DEPTH);
   localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

   tps_rsp_type         entry_ff [OUT_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
         count_ff <= count_ff + CNT_BITS'(push) - CNT_BITS'(pop);
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- rtl/trapezoidal_pulse_shaper.sv -----
// Trapezoidal pulse shaper: one signed ADC sample in per transfer, one shaped
// sample out per transfer. The running sum accumulates x[n]-x[n-k]-x[n-k-l]+x[n-2k-l]
// with k = rise_len (0 acts as 1, clamped to MAX_RISE) and l = flat_len
// (clamped to MAX_FLAT-1); taps that reach before the record start read as
// zero. Output is floor(sum*norm_gain/65536) saturated to 16 bits. tuser on
// the input marks the first sample of a record (restarts position, sum and
// peak), tlast the last one; that sample's result carries the record peak and
// its first position with rsp_tuser high. Throughput is one sample per clock while
// the output queue has room; samples pass the tap fetch, sum, product and queue
// registers. The delay line is two copies of a 2*MAX_RISE+MAX_FLAT entry RAM, each
// written with every sample, so the three taps are read in the same cycle; an 8-entry
// output queue with input credits keeps the input open while results wait. Registers
// must be written only while no samples are in flight; the block does not enforce this.
`default_nettype none
module trapezoidal_pulse_shaper import tps_pkg::*; #(
   parameter int MAX_RISE = 256,
   parameter int MAX_FLAT = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // input stream
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [15:0]               req_tdata,   // sample[13:0], zero pad
   input  wire logic                      req_tuser,   // first_of_record
   input  wire logic                      req_tlast,   // last_of_record
   // result stream
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [47:0]                    rsp_tdata,   // shaped, peak_value, peak_index, pad
   output logic                           rsp_tuser,   // peak_valid
   // register writes
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int OCC_BITS = $clog2(OUT_DEPTH + 1);

   tps_cfg_type           cfg_ff, cfg_in;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic                  accept, pop;
   tps_ctl_type           tap_ctl;
   logic signed [SAMPLE_BITS-1:0] tap_sample, tap_k, tap_kl, tap_2kl;
   logic                  push;
   tps_rsp_type           push_data, out_data;

   // register file; writes to unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_RISE_LEN:  cfg_in.rise_len  = csr_data[RISE_BITS-1:0];
            CSR_FLAT_LEN:  cfg_in.flat_len  = csr_data[FLAT_BITS-1:0];
            CSR_NORM_GAIN: cfg_in.norm_gain = csr_data[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // credits: every accepted sample owns a queue slot until its result transfers
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (occ_ff < OCC_BITS'(OUT_DEPTH));
   assign occ_in     = occ_ff + OCC_BITS'(accept) - OCC_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rise_len  <= RISE_BITS'(16);
         cfg_ff.flat_len  <= FLAT_BITS'(8);
         cfg_ff.norm_gain <= GAIN_BITS'(4096);
         occ_ff           <= '0;
      end else begin
         cfg_ff <= cfg_in;
         occ_ff <= occ_in;
      end
   end

   // delay line, write pointer, sample position and tap fetch
   tps_delay #(.MAX_RISE(MAX_RISE), .MAX_FLAT(MAX_FLAT)) u_delay (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_sample   ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .in_first    (req_tuser),
      .in_last     (req_tlast),
      .cfg         (cfg_ff),
      .out_ctl     (tap_ctl),
      .out_sample  (tap_sample),
      .out_tap_k   (tap_k),
      .out_tap_kl  (tap_kl),
      .out_tap_2kl (tap_2kl)
   );

   // running sum, gain multiply, saturation and peak tracking
   tps_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .ctl       (tap_ctl),
      .sample    (tap_sample),
      .tap_k     (tap_k),
      .tap_kl    (tap_kl),
      .tap_2kl   (tap_2kl),
      .norm_gain (cfg_ff.norm_gain),
      .push      (push),
      .push_data (push_data)
   );

   // result queue toward the output stream
   tps_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_data  (out_data)
   );

   assign rsp_tdata = {4'b0000, out_data.peak_index, out_data.peak_value, out_data.shaped};
   assign rsp_tuser = out_data.peak_valid;

endmodule
`default_nettype wire

// ----- rtl/tps_checker.sv -----
`default_nettype none
`include "trapezoidal_pulse_shaper_assert.svh"
module tps_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a stalled result holds
   `TPS_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // input only closes when the queue already holds results
   `TPS_ASSERT_IMP(a_full_has_output, clock, reset, !req_tready, rsp_tvalid)

   // peak fields are zero unless flagged
   `TPS_ASSERT_IMP(a_peak_zero, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata[43:16] == 28'd0)

   // the record peak is never below the last sample's shaped value
   `TPS_ASSERT_IMP(a_peak_bound, clock, reset, rsp_tvalid && rsp_tuser,
      $signed(rsp_tdata[31:16]) >= $signed(rsp_tdata[15:0]))

endmodule

bind trapezoidal_pulse_shaper tps_checker u_tps_checker (.*);
`default_nettype wire
